### src/rgbgbc_pkg.sv
`default_nettype none

package rgbgbc_pkg;

	localparam int unsigned PIX_W = 8;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned BRIGHT_W = 10;
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned CFG_DATA_W = 16;

	// luma weights, sum 256
	localparam logic [PIX_W-1:0] LUMA_W_RED = 8'd77;
	localparam logic [PIX_W-1:0] LUMA_W_GREEN = 8'd151;
	localparam logic [PIX_W-1:0] LUMA_W_BLUE = 8'd28;

	// levels carry 8 fraction bits
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd65280;
	localparam logic [LEVEL_W:0] MID_LEVEL = 17'd32768;

	// brightness limits, Q1.8
	localparam logic signed [BRIGHT_W-1:0] BRIGHT_MIN = -10'sd256;
	localparam logic signed [BRIGHT_W-1:0] BRIGHT_MAX = 10'sd256;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

	typedef enum logic [0:0] {
		REG_BRIGHTNESS = 1'b0,
		REG_CONTRAST = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

### src/rgbgbc_pix_if.sv
`default_nettype none

interface rgbgbc_pix_if
	import rgbgbc_pkg::*;
();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### src/rgbgbc_gray_if.sv
`default_nettype none

interface rgbgbc_gray_if
	import rgbgbc_pkg::*;
();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] gray;

	modport source (output valid, output gray, input ready);
	modport sink (input valid, input gray, output ready);
endinterface

`default_nettype wire

### src/rgb_gray_brightness_contrast_top.sv
`default_nettype none

// RGB888 to 8-bit gray with brightness and contrast. Each pixel word on
// 'pixel' becomes one gray word on 'result': luma = (77R + 151G + 28B)/256,
// then brightness (negative scales toward black, positive blends toward
// white), then a contrast stretch about mid-gray with slope gain/256,
// clamped to 0..255. Throughput is one word per clock while 'result' is
// ready. The five stages are: luma sum, brightness multiply, brightness
// add and re-center, contrast multiply, truncate/clamp into the output
// register. Each stage has its own valid bit and loads when it is empty
// or its successor loads, so bubbles close up under backpressure and a
// stalled output still lets the earlier stages fill. Registers: index 0
// brightness_adj (signed Q1.8, saturated to -256..256 when written, reset
// 0); index 1 contrast_gain (unsigned Q8.8, 256 is unity, reset 256).
// Write registers only while the pipeline is empty; words in flight use
// the live register values.
module rgb_gray_brightness_contrast_top
	import rgbgbc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rgbgbc_pix_if.sink                 pixel,
	rgbgbc_gray_if.source              result,
	input  wire logic                  cfg_we,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic signed [BRIGHT_W-1:0] brightness_q;
	logic [GAIN_W-1:0]          contrast_q;
	logic signed [BRIGHT_W-1:0] cfg_bright;

	assign cfg_bright = $signed(cfg_data[BRIGHT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
			contrast_q <= GAIN_UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS: begin
					if (cfg_bright < BRIGHT_MIN)
						brightness_q <= BRIGHT_MIN;
					else if (cfg_bright > BRIGHT_MAX)
						brightness_q <= BRIGHT_MAX;
					else
						brightness_q <= cfg_bright;
				end
				REG_CONTRAST: contrast_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake: a stage loads when empty or when its successor loads
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign pixel.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: luma, exact, at most 65280
	logic [LEVEL_W-1:0] lum_next;
	logic [LEVEL_W-1:0] lum_s1;

	assign lum_next = LEVEL_W'(LUMA_W_RED) * LEVEL_W'(pixel.red)
		+ LEVEL_W'(LUMA_W_GREEN) * LEVEL_W'(pixel.green)
		+ LEVEL_W'(LUMA_W_BLUE) * LEVEL_W'(pixel.blue);

	always_ff @(posedge clk) begin
		if (en_s1 && pixel.valid)
			lum_s1 <= lum_next;
	end

	// stage 2: brightness product
	// negative: lum * (256 + b); positive: (full - lum) * b
	logic                     neg_b;
	logic [LEVEL_W-1:0]       b_oper;
	logic [8:0]               b_k;
	logic [BRIGHT_W-1:0]      b_off;
	logic [LEVEL_W+8:0]       bprod_s2;
	logic [LEVEL_W-1:0]       lum_s2;
	logic                     neg_s2;

	assign neg_b = brightness_q[BRIGHT_W-1];
	assign b_off = brightness_q + BRIGHT_MAX;
	assign b_oper = neg_b ? lum_s1 : FULL_SCALE - lum_s1;
	assign b_k = neg_b ? b_off[8:0] : brightness_q[8:0];

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			bprod_s2 <= b_oper * b_k;
			lum_s2 <= lum_s1;
			neg_s2 <= neg_b;
		end
	end

	// stage 3: finish brightness, re-center about mid-gray
	logic [LEVEL_W-1:0]        b_shift;
	logic [LEVEL_W-1:0]        l1;
	logic signed [LEVEL_W:0]   dev_s3;

	assign b_shift = bprod_s2[LEVEL_W+7:8];
	assign l1 = neg_s2 ? b_shift : lum_s2 + b_shift;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2)
			dev_s3 <= $signed({1'b0, l1} - MID_LEVEL);
	end

	// stage 4: contrast product, Q17.16 signed
	logic signed [2*LEVEL_W+1:0] cprod_s4;
	logic signed [GAIN_W:0]      gain_sgn;

	assign gain_sgn = $signed({1'b0, contrast_q});

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3)
			cprod_s4 <= (2*LEVEL_W+2)'(dev_s3) * (2*LEVEL_W+2)'(gain_sgn);
	end

	// stage 5: add mid-gray back, clamp to 0..255
	logic signed [2*LEVEL_W+1:0] t_full;
	logic [PIX_W-1:0]            gray_next;
	logic [PIX_W-1:0]            gray_s5;

	assign t_full = cprod_s4 + (2*LEVEL_W+2)'({MID_LEVEL, 8'd0});

	always_comb begin
		if (t_full[2*LEVEL_W+1])
			gray_next = '0;
		else if (|t_full[2*LEVEL_W:24])
			gray_next = '1;
		else
			gray_next = t_full[23:16];
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4)
			gray_s5 <= gray_next;
	end

	assign result.valid = v_s5;
	assign result.gray = gray_s5;

	// checks
	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		(brightness_q >= BRIGHT_MIN) && (brightness_q <= BRIGHT_MAX))
		else $error("brightness register out of range");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> v_s1)
		else $error("accepted word not captured in stage 1");

	a_s4_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5) |=> v_s5)
		else $error("word lost between stage 4 and output");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s4 && v_s3 && contrast_q == '0) |=> (cprod_s4 == '0))
		else $error("zero gain gave nonzero contrast product");

endmodule

`default_nettype wire
